// ----- rtl/vpz_pkg.sv -----
// ----------------------------------------------------------------------------
// vpz_pkg: shared types and constants for the pan/zoom view transform
// Operation codes of the shared arithmetic unit, handshake structs between
// the sequencer and that unit, stream layout and saturation helpers.
// ----------------------------------------------------------------------------
package vpz_pkg;

  // stream layout
  localparam int IN_TDATA_W  = 192;
  localparam int OUT_TDATA_W = 264;
  localparam int PADDR_W     = 5;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_BOUND_LEFT   = 3'd0;
  localparam logic [2:0] REG_BOUND_RIGHT  = 3'd1;
  localparam logic [2:0] REG_BOUND_BOTTOM = 3'd2;
  localparam logic [2:0] REG_BOUND_TOP    = 3'd3;
  localparam logic [2:0] REG_PLANE_NEAR   = 3'd4;
  localparam logic [2:0] REG_PLANE_FAR    = 3'd5;
  localparam logic [2:0] REG_PAN_ENABLE   = 3'd6;

  // item kinds
  localparam logic [1:0] KIND_PAN   = 2'd0;
  localparam logic [1:0] KIND_ZOOM  = 2'd1;
  localparam logic [1:0] KIND_FIT   = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  // result status
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_SAT     = 2'd2;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_MUL,    // (a*b) >>> FRAC_BITS
    OP_MULH,   // (a*b) >>> 1
    OP_DIV,    // (a << FRAC_BITS) / b
    OP_DIV2,   // (a << 1) / b
    OP_HALF    // a / 2, toward zero
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic dz;    // divisor was zero
  } alu_rsp_t;

  function automatic logic signed [31:0] sat_s33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? S32_MIN : S32_MAX;
    else                r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat_s64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if ((&v[63:31]) || !(|v[63:31])) r = v[31:0];
    else                              r = v[63] ? S32_MIN : S32_MAX;
    return r;
  endfunction

endpackage

// ----- rtl/vpz_div.sv -----
// ----------------------------------------------------------------------------
// vpz_div: iterative signed divider
// Restoring divide on magnitudes, one quotient bit per cycle, truncating
// toward zero and saturating to 32 bits. Zero divisor saturates by the dividend's sign; zero over zero gives zero.
// ----------------------------------------------------------------------------
module vpz_div
  import vpz_pkg::*;
#(
  parameter int DVW = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [DVW-1:0] dividend,
  input  logic signed [31:0]    divisor,
  output logic                  done,
  output logic                  dz,
  output logic signed [31:0]    q
);

  localparam int CNT_W = $clog2(DVW + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t          st;
  logic [DVW-1:0]   num;
  logic [31:0]      den;
  logic [31:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [32:0]      trial;
  logic             fits;
  logic [DVW-1:0]   lim;

  assign trial = {rem, num[DVW-1]};
  assign fits  = trial >= {1'b0, den};
  assign lim   = neg ? DVW'(32'h8000_0000) : DVW'(32'h7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= D_IDLE;
      done <= 1'b0;
      dz   <= 1'b0;
    end else begin
      unique case (st)
        D_IDLE: begin
          // zero divisor answers at once
          done <= start && (divisor == 32'sd0);
          dz   <= start && (divisor == 32'sd0);
          if (start) begin
            neg <= dividend[DVW-1] ^ divisor[31];
            if (divisor == 32'sd0) begin
              if (dividend[DVW-1])          q <= S32_MIN;
              else if (dividend == '0)      q <= 32'sd0;
              else                          q <= S32_MAX;
            end else begin
              num <= dividend[DVW-1] ? DVW'('0 - unsigned'(dividend)) : unsigned'(dividend);
              den <= divisor[31] ? 32'('0 - unsigned'(divisor)) : unsigned'(divisor);
              rem <= '0;
              cnt <= '0;
              st  <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
          num <= {num[DVW-2:0], fits};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DVW - 1)) st <= D_FIN;
        end
        D_FIN: begin
          if (num > lim) q <= neg ? S32_MIN : S32_MAX;
          else           q <= neg ? 32'('0 - num[31:0]) : num[31:0];
          done <= 1'b1;
          st   <= D_IDLE;
        end
        default: st <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/vpz_alu.sv -----
// ----------------------------------------------------------------------------
// vpz_alu: shared fixed-point arithmetic unit
// Saturating add/sub and halving, multiply with shift through a product
// register, and divide through the iterative divider. One request at a time.
// ----------------------------------------------------------------------------
module vpz_alu
  import vpz_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  alu_req_t           req,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output alu_rsp_t           rsp,
  output logic signed [31:0] y
);

  localparam int DVW = 32 + FRAC_BITS;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} astate_t;

  astate_t               st;
  logic signed [63:0]    prod;
  logic                  prod_half;
  logic signed [63:0]    prod_sh;
  logic signed [32:0]    sum;
  logic signed [31:0]    half;
  logic signed [DVW-1:0] a_ext;
  logic signed [DVW-1:0] dvd;
  logic                  div_start;
  logic                  div_done;
  logic                  div_dz;
  logic signed [31:0]    div_q;
  logic                  quick;

  assign a_ext     = DVW'(a);
  assign dvd       = (req.op == OP_DIV2) ? (a_ext <<< 1) : (a_ext <<< FRAC_BITS);
  assign div_start = req.start && (st == A_IDLE) && (req.op == OP_DIV || req.op == OP_DIV2);
  assign prod_sh   = prod_half ? (prod >>> 1) : (prod >>> FRAC_BITS);
  assign sum       = (req.op == OP_SUB) ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
  // negative values get +1 first so the shift truncates toward zero
  assign half      = (a + $signed({31'd0, a[31]})) >>> 1;
  assign quick     = req.start && (req.op == OP_ADD || req.op == OP_SUB || req.op == OP_HALF);

  vpz_div #(.DVW(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (b),
    .done     (div_done),
    .dz       (div_dz),
    .q        (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= A_IDLE;
      rsp <= '0;
    end else begin
      unique case (st)
        A_IDLE: begin
          rsp <= '{done: quick, dz: 1'b0};
          if (req.start) begin
            unique case (req.op)
              OP_ADD, OP_SUB: y <= sat_s33(sum);
              OP_HALF:        y <= half;
              OP_MUL, OP_MULH: begin
                prod      <= 64'(a) * 64'(b);
                prod_half <= (req.op == OP_MULH);
                st        <= A_MUL;
              end
              OP_DIV, OP_DIV2: st <= A_DIV;
              default: ;
            endcase
          end
        end
        A_MUL: begin
          y   <= sat_s64(prod_sh);
          rsp <= '{done: 1'b1, dz: 1'b0};
          st  <= A_IDLE;
        end
        A_DIV: begin
          rsp <= '{done: div_done, dz: div_done && div_dz};
          if (div_done) begin
            y  <= div_q;
            st <= A_IDLE;
          end
        end
        default: begin
          rsp <= '0;
          st  <= A_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/viewport_pan_zoom_transform_core.sv -----
// ----------------------------------------------------------------------------
// viewport_pan_zoom_transform_core: 2D orthographic pan/zoom camera
// Holds view scale and shift in signed fixed point, applies pan, zoom about
// a point, fit to rectangle or screen-to-world query, and returns the
// combined projection*view terms. All math runs through one shared unit.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+--------------------------------------
//  s_      | in  | s_tvalid / s_tready   | tdata: width,height,point,corner,zoom
//          |     |                       | tuser: kind
//  m_      | out | m_tvalid / m_tready   | tdata: 6 mvp terms, world x/y, status
//  apb     | in  | psel,penable,pwrite   | 7 registers at 4*i, pready tied high
//
//  An ignored word runs only the prologue and epilogue steps; a zoom runs
//  the most divides (14). Every divide holds the bit-serial divider
//  (a zero divisor answers early); multiplies, adds and halvings are
//  shorter, and each step issues its request before waiting on the unit.
//  s_tready is high only while the sequencer is idle; a finished word may
//  still sit in the output register then. A stall on m_tready holds the
//  sequencer in its final step. Reset is synchronous; no clearing pass.
//
module viewport_pan_zoom_transform_core
  import vpz_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // view_width[15:0], view_height[31:16], point_x[63:32], point_y[95:64],
  // corner_x[127:96], corner_y[159:128], zoom_factor[190:160], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // kind[1:0]
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // mvp_scale_x[31:0], mvp_offset_x[63:32], mvp_scale_y[95:64],
  // mvp_offset_y[127:96], mvp_scale_z[159:128], mvp_offset_z[191:160],
  // world_x[223:192], world_y[255:224], status[257:256], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam logic signed [31:0] Q_ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] Q_TWO  = 32'sd2 <<< FRAC_BITS;
  localparam logic signed [31:0] Q_MTWO = -Q_TWO;

  // step program: prologue (projection terms), per-kind body, epilogue
  typedef enum logic [5:0] {
    ST_IDLE,
    P_DX, P_P0, P_SX, P_DVX, P_TX,
    P_DY, P_P5, P_SY, P_DVY, P_TY,
    P_DZ, P_SZ, P_SUMZ, P_DVZ, P_OZ,
    N_HX, N_DX, N_AX, N_HY, N_NY, N_DY, N_AY,
    W_NX, W_SX, W_MX, W_DX, W_QX, W_NY, W_SY, W_MY, W_DY, W_QY,
    Z_CX, Z_CY, Z_SC, Z_DX, Z_AX, Z_DY, Z_AY,
    F_WW, F_WH, F_AS, F_SX, F_SY, F_RA, F_CM, F_SEL,
    F_HX, F_PX, F_NX, F_HY, F_PY, F_NY,
    E_SX, E_MX, E_PX, E_OX, E_SY, E_MY, E_PY, E_OY,
    ST_DONE
  } step_t;

  typedef enum logic [4:0] {
    D_NONE, D_T0, D_T1, D_T2, D_T3, D_T4, D_T5,
    D_P0, D_P5, D_TX, D_TY, D_SZ, D_OZ, D_QX, D_QY,
    D_SCALE, D_SX, D_SY
  } dst_t;

  // configuration
  logic signed [31:0] bnd_l, bnd_r, bnd_b, bnd_t, pln_n, pln_f;
  logic               pan_en;
  logic               cfg_wr;

  // view state
  logic signed [31:0] scale, shx, shy;

  // latched word
  logic [1:0]         kind;
  logic [15:0]        vw, vh;
  logic signed [31:0] px, py, cx, cy;
  logic [30:0]        zf;
  logic               empty;
  logic               ign;

  // work registers
  logic signed [31:0] t0, t1, t2, t3, t4, t5;
  logic signed [31:0] p0, p5, tx, ty, sz, oz, qx, qy;

  // sequencer
  step_t              step, step_next;
  dst_t               dst;
  logic               issued;
  logic               zpass;     // second world mapping of a zoom
  logic               dz_acc;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  alu_op_t            op;
  logic signed [31:0] opa, opb, alu_y;
  logic [OUT_TDATA_W-1:0] m_data_r;
  logic [1:0]         stat;
  logic               wsel;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign s_tready = (step == ST_IDLE);
  assign m_tdata  = m_data_r;

  always_comb begin
    unique case (paddr[4:2])
      REG_BOUND_LEFT:   prdata = bnd_l;
      REG_BOUND_RIGHT:  prdata = bnd_r;
      REG_BOUND_BOTTOM: prdata = bnd_b;
      REG_BOUND_TOP:    prdata = bnd_t;
      REG_PLANE_NEAR:   prdata = pln_n;
      REG_PLANE_FAR:    prdata = pln_f;
      REG_PAN_ENABLE:   prdata = {31'd0, pan_en};
      default:          prdata = 32'd0;
    endcase
  end

  // Step decode: operation, operands, destination and successor.
  always_comb begin
    op        = OP_NONE;
    opa       = 32'sd0;
    opb       = 32'sd0;
    dst       = D_NONE;
    step_next = step;
    unique case (step)
      // projection x: P0 = 2/(r-l), Tx = -(r+l)/(r-l)
      P_DX:  begin op = OP_SUB; opa = bnd_r; opb = bnd_l; dst = D_T0; step_next = P_P0; end
      P_P0:  begin op = OP_DIV; opa = Q_TWO; opb = t0;    dst = D_P0; step_next = P_SX; end
      P_SX:  begin op = OP_ADD; opa = bnd_r; opb = bnd_l; dst = D_T1; step_next = P_DVX; end
      P_DVX: begin op = OP_DIV; opa = t1;    opb = t0;    dst = D_T1; step_next = P_TX; end
      P_TX:  begin op = OP_SUB; opa = 32'sd0; opb = t1;   dst = D_TX; step_next = P_DY; end
      // projection y
      P_DY:  begin op = OP_SUB; opa = bnd_t; opb = bnd_b; dst = D_T0; step_next = P_P5; end
      P_P5:  begin op = OP_DIV; opa = Q_TWO; opb = t0;    dst = D_P5; step_next = P_SY; end
      P_SY:  begin op = OP_ADD; opa = bnd_t; opb = bnd_b; dst = D_T1; step_next = P_DVY; end
      P_DVY: begin op = OP_DIV; opa = t1;    opb = t0;    dst = D_T1; step_next = P_TY; end
      P_TY:  begin op = OP_SUB; opa = 32'sd0; opb = t1;   dst = D_TY; step_next = P_DZ; end
      // depth
      P_DZ:   begin op = OP_SUB; opa = pln_f;  opb = pln_n; dst = D_T0; step_next = P_SZ; end
      P_SZ:   begin op = OP_DIV; opa = Q_MTWO; opb = t0;    dst = D_SZ; step_next = P_SUMZ; end
      P_SUMZ: begin op = OP_ADD; opa = pln_f;  opb = pln_n; dst = D_T1; step_next = P_DVZ; end
      P_DVZ:  begin op = OP_DIV; opa = t1;     opb = t0;    dst = D_T1; step_next = P_OZ; end
      P_OZ: begin
        op = OP_SUB; opa = 32'sd0; opb = t1; dst = D_OZ;
        if (ign)                    step_next = E_SX;
        else if (kind == KIND_PAN)  step_next = N_HX;
        else if (kind == KIND_FIT)  step_next = F_WW;
        else                        step_next = W_NX;
      end
      // pan: shift += delta / floor(s*size/2), with the y delta negated
      N_HX: begin op = OP_MULH; opa = scale; opb = {16'd0, vw}; dst = D_T0; step_next = N_DX; end
      N_DX: begin op = OP_DIV;  opa = px;    opb = t0;          dst = D_T0; step_next = N_AX; end
      N_AX: begin op = OP_ADD;  opa = shx;   opb = t0;          dst = D_SX; step_next = N_HY; end
      N_HY: begin op = OP_MULH; opa = scale; opb = {16'd0, vh}; dst = D_T0; step_next = N_NY; end
      N_NY: begin op = OP_SUB;  opa = 32'sd0; opb = py;         dst = D_T1; step_next = N_DY; end
      N_DY: begin op = OP_DIV;  opa = t1;    opb = t0;          dst = D_T1; step_next = N_AY; end
      N_AY: begin op = OP_ADD;  opa = shy;   opb = t1;          dst = D_SY; step_next = E_SX; end
      // screen to world into qx, qy
      W_NX: begin op = OP_DIV2; opa = px;    opb = {16'd0, vw}; dst = D_T0; step_next = W_SX; end
      W_SX: begin op = OP_SUB;  opa = t0;    opb = Q_ONE;       dst = D_T0; step_next = W_MX; end
      W_MX: begin op = OP_MUL;  opa = p0;    opb = scale;       dst = D_T1; step_next = W_DX; end
      W_DX: begin op = OP_DIV;  opa = t0;    opb = t1;          dst = D_T0; step_next = W_QX; end
      W_QX: begin op = OP_SUB;  opa = t0;    opb = shx;         dst = D_QX; step_next = W_NY; end
      W_NY: begin op = OP_DIV2; opa = py;    opb = {16'd0, vh}; dst = D_T0; step_next = W_SY; end
      W_SY: begin op = OP_SUB;  opa = Q_ONE; opb = t0;          dst = D_T0; step_next = W_MY; end
      W_MY: begin op = OP_MUL;  opa = p5;    opb = scale;       dst = D_T1; step_next = W_DY; end
      W_DY: begin op = OP_DIV;  opa = t0;    opb = t1;          dst = D_T0; step_next = W_QY; end
      W_QY: begin
        op = OP_SUB; opa = t0; opb = shy; dst = D_QY;
        if (kind == KIND_QUERY) step_next = E_SX;
        else if (zpass)         step_next = Z_DX;
        else                    step_next = Z_CX;
      end
      // zoom about point
      Z_CX: begin op = OP_ADD; opa = qx;    opb = 32'sd0;      dst = D_T2;    step_next = Z_CY; end
      Z_CY: begin op = OP_ADD; opa = qy;    opb = 32'sd0;      dst = D_T3;    step_next = Z_SC; end
      Z_SC: begin op = OP_MUL; opa = scale; opb = {1'b0, zf};  dst = D_SCALE; step_next = W_NX; end
      Z_DX: begin op = OP_SUB; opa = t2;    opb = qx;          dst = D_T2;    step_next = Z_AX; end
      Z_AX: begin op = OP_ADD; opa = shx;   opb = t2;          dst = D_SX;    step_next = Z_DY; end
      Z_DY: begin op = OP_SUB; opa = t3;    opb = qy;          dst = D_T3;    step_next = Z_AY; end
      Z_AY: begin op = OP_ADD; opa = shy;   opb = t3;          dst = D_SY;    step_next = E_SX; end
      // fit rectangle
      F_WW: begin op = OP_SUB; opa = cx;    opb = px;          dst = D_T0; step_next = F_WH; end
      F_WH: begin op = OP_SUB; opa = cy;    opb = py;          dst = D_T1; step_next = F_AS; end
      F_AS: begin op = OP_DIV; opa = {16'd0, vw}; opb = {16'd0, vh}; dst = D_T2; step_next = F_SX; end
      F_SX: begin op = OP_DIV; opa = Q_TWO; opb = t0;          dst = D_T3; step_next = F_SY; end
      F_SY: begin op = OP_DIV; opa = Q_TWO; opb = t1;          dst = D_T4; step_next = F_RA; end
      F_RA: begin op = OP_DIV; opa = t0;    opb = t1;          dst = D_T5; step_next = F_CM; end
      // saturating difference keeps the sign of the compare
      F_CM: begin op = OP_SUB; opa = t5;    opb = t2;          dst = D_T5; step_next = F_SEL; end
      F_SEL: step_next = F_HX;
      // half extent: divide by 2.0 is a truncating halving
      F_HX: begin op = OP_HALF; opa = t0;   opb = 32'sd0;      dst = D_T0; step_next = F_PX; end
      F_PX: begin op = OP_ADD; opa = px;    opb = t0;          dst = D_T0; step_next = F_NX; end
      F_NX: begin op = OP_SUB; opa = 32'sd0; opb = t0;         dst = D_SX; step_next = F_HY; end
      F_HY: begin op = OP_HALF; opa = t1;   opb = 32'sd0;      dst = D_T1; step_next = F_PY; end
      F_PY: begin op = OP_ADD; opa = py;    opb = t1;          dst = D_T1; step_next = F_NY; end
      F_NY: begin op = OP_SUB; opa = 32'sd0; opb = t1;         dst = D_SY; step_next = E_SX; end
      // combined terms into t2..t5
      E_SX: begin op = OP_MUL; opa = p0;    opb = scale;       dst = D_T2; step_next = E_MX; end
      E_MX: begin op = OP_MUL; opa = scale; opb = shx;         dst = D_T0; step_next = E_PX; end
      E_PX: begin op = OP_MUL; opa = p0;    opb = t0;          dst = D_T0; step_next = E_OX; end
      E_OX: begin op = OP_ADD; opa = t0;    opb = tx;          dst = D_T3; step_next = E_SY; end
      E_SY: begin op = OP_MUL; opa = p5;    opb = scale;       dst = D_T4; step_next = E_MY; end
      E_MY: begin op = OP_MUL; opa = scale; opb = shy;         dst = D_T0; step_next = E_PY; end
      E_PY: begin op = OP_MUL; opa = p5;    opb = t0;          dst = D_T0; step_next = E_OY; end
      E_OY: begin op = OP_ADD; opa = t0;    opb = ty;          dst = D_T5; step_next = ST_DONE; end
      default: ;
    endcase
  end

  assign alu_req.start = !issued && (op != OP_NONE);
  assign alu_req.op    = op;

  vpz_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (opa),
    .b   (opb),
    .rsp (alu_rsp),
    .y   (alu_y)
  );

  assign stat = ign ? STAT_IGNORED : (dz_acc ? STAT_SAT : STAT_OK);
  assign wsel = (kind == KIND_QUERY) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_l    <= -Q_ONE;
      bnd_r    <= Q_ONE;
      bnd_b    <= -Q_ONE;
      bnd_t    <= Q_ONE;
      pln_n    <= -Q_ONE;
      pln_f    <= Q_ONE;
      pan_en   <= 1'b1;
      scale    <= Q_ONE;
      shx      <= 32'sd0;
      shy      <= 32'sd0;
      step     <= ST_IDLE;
      issued   <= 1'b0;
      zpass    <= 1'b0;
      dz_acc   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_BOUND_LEFT:   bnd_l  <= pwdata;
          REG_BOUND_RIGHT:  bnd_r  <= pwdata;
          REG_BOUND_BOTTOM: bnd_b  <= pwdata;
          REG_BOUND_TOP:    bnd_t  <= pwdata;
          REG_PLANE_NEAR:   pln_n  <= pwdata;
          REG_PLANE_FAR:    pln_f  <= pwdata;
          REG_PAN_ENABLE:   pan_en <= pwdata[0];
          default: ;
        endcase
      end

      // in the final step the output register is reloaded instead
      if (m_tvalid && m_tready && step != ST_DONE) m_tvalid <= 1'b0;

      if (step == ST_IDLE) begin
        if (s_tvalid) begin
          kind   <= s_tuser;
          vw     <= s_tdata[15:0];
          vh     <= s_tdata[31:16];
          px     <= s_tdata[63:32];
          py     <= s_tdata[95:64];
          cx     <= s_tdata[127:96];
          cy     <= s_tdata[159:128];
          zf     <= s_tdata[190:160];
          empty  <= (s_tdata[15:0] == 16'd0) || (s_tdata[31:16] == 16'd0);
          ign    <= (s_tdata[15:0] == 16'd0) || (s_tdata[31:16] == 16'd0) ||
                    (!pan_en && (s_tuser == KIND_PAN || s_tuser == KIND_ZOOM));
          dz_acc <= 1'b0;
          zpass  <= 1'b0;
          issued <= 1'b0;
          step   <= P_DX;
        end
      end else if (step == ST_DONE) begin
        // wait for the output register to free up
        if (!m_tvalid || m_tready) begin
          m_data_r <= {6'd0, stat,
                       wsel ? qy : 32'sd0, wsel ? qx : 32'sd0,
                       oz, sz, t5, t4, t3, t2};
          m_tvalid <= 1'b1;
          step     <= ST_IDLE;
        end
      end else if (step == F_SEL) begin
        scale <= (!t5[31] && (t5 != 32'sd0)) ? t3 : t4;
        step  <= step_next;
      end else if (!issued) begin
        issued <= 1'b1;
      end else if (alu_rsp.done) begin
        issued <= 1'b0;
        dz_acc <= dz_acc | alu_rsp.dz;
        if (step == Z_SC) zpass <= 1'b1;
        step   <= step_next;
        unique case (dst)
          D_T0:    t0    <= alu_y;
          D_T1:    t1    <= alu_y;
          D_T2:    t2    <= alu_y;
          D_T3:    t3    <= alu_y;
          D_T4:    t4    <= alu_y;
          D_T5:    t5    <= alu_y;
          D_P0:    p0    <= alu_y;
          D_P5:    p5    <= alu_y;
          D_TX:    tx    <= alu_y;
          D_TY:    ty    <= alu_y;
          D_SZ:    sz    <= alu_y;
          D_OZ:    oz    <= alu_y;
          D_QX:    qx    <= alu_y;
          D_QY:    qy    <= alu_y;
          D_SCALE: scale <= alu_y;
          D_SX:    shx   <= alu_y;
          D_SY:    shy   <= alu_y;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/vpz_chk.sv -----
// ----------------------------------------------------------------------------
// vpz_chk: port-level checks for the view transform core
// Watches the stream ports over time; attached to the core by bind.
// ----------------------------------------------------------------------------
module vpz_chk
  import vpz_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // one word in flight: intake closes right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a word is in flight");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[257:256] == STAT_OK || m_tdata[257:256] == STAT_IGNORED ||
                  m_tdata[257:256] == STAT_SAT))
    else $error("bad status code");

  // ignored words never carry a world point
  a_ign_world: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[257:256] == STAT_IGNORED) |-> (m_tdata[255:192] == '0))
    else $error("world point on ignored word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("output word dropped under stall");

  a_reset: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("bad state after reset");

endmodule

bind viewport_pan_zoom_transform_core vpz_chk u_vpz_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
